>>> rtl/lhbp_pkg.sv
package lhbp_pkg;

  localparam int PC_BITS = 32;

  // Item kinds carried in the mode field.
  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  // Target reported when there is no taken prediction with a buffer hit.
  localparam logic [PC_BITS-1:0] NO_TARGET = '1;

  typedef struct packed {
    logic               mode;
    logic [PC_BITS-1:0] pc;
    logic               taken;
    logic [PC_BITS-1:0] actual_target;
  } req_t;

  typedef struct packed {
    logic               predict_taken;
    logic [PC_BITS-1:0] predicted_target;
    logic               mispredicted;
  } rsp_t;

endpackage

>>> rtl/lhbp_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module lhbp_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/local_history_branch_predictor_btb_top.sv
// Channel | Handshake            | Payload         | Carries
// --------+----------------------+-----------------+-------------------------------------
// req     | req_valid, req_ready | lhbp_pkg::req_t | lookup or update: mode, pc, outcome
// rsp     | rsp_valid, rsp_ready | lhbp_pkg::rsp_t | prediction, target, mispredict flag
//
// Each item passes from its transfer on req through S_HIST, S_CNT and S_DONE
// to its result being loaded into the rsp register. S_HIST and S_CNT see the
// dependent memory reads (history, then pattern counter), with the write-back
// made in the cycle the counter arrives; S_DONE hands the result over. A new
// request is taken only in S_IDLE, once S_DONE has handed the result over.
// After reset a clearing pass walks every index below 2**max(HISTORY_INDEX_BITS,
// HISTORY_BITS, TARGET_INDEX_BITS) (1024 by default) and zeroes every table;
// req_ready stays low meanwhile. A stalled rsp holds only the finished result:
// a new request can be taken while it waits.
module local_history_branch_predictor_btb_top #(
  parameter int HISTORY_INDEX_BITS = 10,
  parameter int HISTORY_BITS       = 8,
  parameter int COUNTER_BITS       = 2,
  parameter int TARGET_INDEX_BITS  = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lhbp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lhbp_pkg::rsp_t rsp
);

  localparam int PCB = lhbp_pkg::PC_BITS;
  localparam int MAX_IH = (HISTORY_INDEX_BITS > HISTORY_BITS) ?
                          HISTORY_INDEX_BITS : HISTORY_BITS;
  localparam int CLR_BITS = (MAX_IH > TARGET_INDEX_BITS) ? MAX_IH : TARGET_INDEX_BITS;

  // The sequencer walks each item through read, read, write-back and hand-off.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HIST,
    S_CNT,
    S_DONE
  } state_t;

  state_t            state;
  lhbp_pkg::req_t    item;
  logic [CLR_BITS-1:0] clr_idx;
  logic [HISTORY_BITS-1:0] hist;
  logic [PCB-1:0]    btb_tag;
  logic [PCB-1:0]    btb_target;
  lhbp_pkg::rsp_t    res;

  // Memory ports.
  logic                          hist_we;
  logic [HISTORY_INDEX_BITS-1:0] hist_waddr;
  logic [HISTORY_BITS-1:0]       hist_wdata;
  logic                          hist_re;
  logic [HISTORY_BITS-1:0]       hist_rdata;

  logic                    cnt_we;
  logic [HISTORY_BITS-1:0] cnt_waddr;
  logic [COUNTER_BITS-1:0] cnt_wdata;
  logic                    cnt_re;
  logic [COUNTER_BITS-1:0] cnt_rdata;

  logic                         btb_we;
  logic [TARGET_INDEX_BITS-1:0] btb_waddr;
  logic [2*PCB-1:0]             btb_wdata;
  logic                         btb_re;
  logic [2*PCB-1:0]             btb_rdata;

  // Prediction and training logic, evaluated in the write-back cycle.
  logic                    pred;
  logic                    hit;
  logic                    upd;
  logic                    mis;
  logic [COUNTER_BITS-1:0] ctr_next;
  logic [HISTORY_BITS-1:0] hist_next;
  logic                    req_fire;
  logic                    rsp_load;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  // The finished result moves into the output register once that is free.
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // A counter whose top bit is set lies in the upper half of its range.
  assign pred = cnt_rdata[COUNTER_BITS-1];
  assign hit  = (btb_tag == item.pc);
  assign upd  = (item.mode == lhbp_pkg::MODE_UPDATE);
  assign mis  = upd && !((hit && pred && item.taken) || (!hit && !pred && !item.taken));

  // The counter only moves when its direction disagrees with the outcome, so
  // it steps towards the other half and can never wrap.
  always_comb begin
    ctr_next = cnt_rdata;
    if (!pred && item.taken) begin
      ctr_next = cnt_rdata + 1'b1;
    end else if (pred && !item.taken) begin
      ctr_next = cnt_rdata - 1'b1;
    end
  end

  // Shift the outcome into the bottom of the local history.
  always_comb begin
    logic [HISTORY_BITS:0] shifted;
    shifted   = {hist, item.taken};
    hist_next = shifted[HISTORY_BITS-1:0];
  end

  // Memory control: the clearing pass writes zeroes everywhere; otherwise
  // reads are issued as the item advances and writes land in the
  // write-back cycle. Only one item is in flight, so a read never overlaps
  // a pending write to the same entry.
  always_comb begin
    hist_re    = req_fire;
    btb_re     = req_fire;
    cnt_re     = (state == S_HIST);
    hist_we    = 1'b0;
    cnt_we     = 1'b0;
    btb_we     = 1'b0;
    hist_waddr = item.pc[HISTORY_INDEX_BITS-1:0];
    cnt_waddr  = hist;
    btb_waddr  = item.pc[TARGET_INDEX_BITS-1:0];
    hist_wdata = hist_next;
    cnt_wdata  = ctr_next;
    btb_wdata  = {item.pc, item.actual_target};
    unique case (state)
      S_CLEAR: begin
        hist_we    = 1'b1;
        cnt_we     = 1'b1;
        btb_we     = 1'b1;
        hist_waddr = clr_idx[HISTORY_INDEX_BITS-1:0];
        cnt_waddr  = clr_idx[HISTORY_BITS-1:0];
        btb_waddr  = clr_idx[TARGET_INDEX_BITS-1:0];
        hist_wdata = '0;
        cnt_wdata  = '0;
        btb_wdata  = '0;
      end
      S_CNT: begin
        hist_we = upd;
        cnt_we  = upd;
        btb_we  = mis && item.taken;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_HIST;
          end
        end
        S_HIST: begin
          hist       <= hist_rdata;
          btb_tag    <= btb_rdata[2*PCB-1:PCB];
          btb_target <= btb_rdata[PCB-1:0];
          state      <= S_CNT;
        end
        S_CNT: begin
          res.predict_taken    <= pred;
          res.predicted_target <= (hit && pred) ? btb_target : lhbp_pkg::NO_TARGET;
          res.mispredicted     <= mis;
          state                <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (rsp_load) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lhbp_ram #(
    .WIDTH    (HISTORY_BITS),
    .ADDR_BITS(HISTORY_INDEX_BITS)
  ) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .re   (hist_re),
    .raddr(req.pc[HISTORY_INDEX_BITS-1:0]),
    .rdata(hist_rdata)
  );

  lhbp_ram #(
    .WIDTH    (COUNTER_BITS),
    .ADDR_BITS(HISTORY_BITS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .re   (cnt_re),
    .raddr(hist_rdata),
    .rdata(cnt_rdata)
  );

  // Each buffer entry holds the full tag above the target.
  lhbp_ram #(
    .WIDTH    (2*PCB),
    .ADDR_BITS(TARGET_INDEX_BITS)
  ) u_btb_ram (
    .clk  (clk),
    .we   (btb_we),
    .waddr(btb_waddr),
    .wdata(btb_wdata),
    .re   (btb_re),
    .raddr(req.pc[TARGET_INDEX_BITS-1:0]),
    .rdata(btb_rdata)
  );

endmodule

>>> sim/tb_local_history_branch_predictor_btb_top.sv
module tb_local_history_branch_predictor_btb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the block under test. These are passed to the instance
  // explicitly so that the local predictor and the RTL always agree.
  localparam int HIST_IDX_W = 10;
  localparam int HIST_W     = 8;
  localparam int CTR_W      = 2;
  localparam int TGT_IDX_W  = 9;
  localparam int PCW        = lhbp_pkg::PC_BITS;

  // The clearing pass after reset makes no transfer, so the watchdog must
  // comfortably outlast it as well as the longest idle bursts.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int POOL_SIZE      = 16;

  typedef enum int {
    ALWAYS_TAKEN,
    NEVER_TAKEN,
    LOOP_EXIT,
    COIN_FLIP
  } branch_habit_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b1;
  lhbp_pkg::req_t req = '0;
  logic req_ready;
  logic rsp_valid;
  lhbp_pkg::rsp_t rsp;

  local_history_branch_predictor_btb_top #(
    .HISTORY_INDEX_BITS(HIST_IDX_W),
    .HISTORY_BITS      (HIST_W),
    .COUNTER_BITS      (CTR_W),
    .TARGET_INDEX_BITS (TGT_IDX_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the predictor's tables. It is trained in the same order
  // as the block sees the requests, i.e. in order of transfer on req.
  logic [HIST_W-1:0] shadow_history [1 << HIST_IDX_W];
  logic [CTR_W-1:0]  shadow_counter [1 << HIST_W];
  logic [PCW-1:0]    shadow_tag     [1 << TGT_IDX_W];
  logic [PCW-1:0]    shadow_target  [1 << TGT_IDX_W];

  // Predictions still owed by the block, oldest first.
  lhbp_pkg::rsp_t owed_predictions [$];

  // Idling controls, in percent chance of starting a burst (per request on req, per cycle on rsp).
  int req_gap_pct   = 0;
  int rsp_stall_pct = 0;

  int mismatches     = 0;
  int lookups_sent   = 0;
  int updates_sent   = 0;
  int mispredicts    = 0;
  int target_hits    = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;

  // A small set of recurring branches, so that histories, counters and the
  // target buffer actually get trained. Some share table indexes with
  // others but carry a different full address, to exercise tag misses.
  logic [PCW-1:0] pool_pc     [POOL_SIZE];
  logic [PCW-1:0] pool_target [POOL_SIZE];
  branch_habit_t  pool_habit  [POOL_SIZE];
  int             pool_period [POOL_SIZE];
  int             pool_visits [POOL_SIZE];

  // Works out the result the block owes for one request and then applies
  // the training that an update causes. Every decision uses the state from
  // before the update.
  function automatic lhbp_pkg::rsp_t predict_and_train(input lhbp_pkg::req_t item);
    logic [HIST_IDX_W-1:0] hidx;
    logic [TGT_IDX_W-1:0]  tidx;
    logic [HIST_W-1:0]     hist;
    logic [CTR_W-1:0]      ctr;
    logic                  tag_hit;
    lhbp_pkg::rsp_t        result;
    hidx    = item.pc[HIST_IDX_W-1:0];
    tidx    = item.pc[TGT_IDX_W-1:0];
    hist    = shadow_history[hidx];
    ctr     = shadow_counter[hist];
    tag_hit = (shadow_tag[tidx] == item.pc);
    // Upper half of the counter range means predict taken.
    result.predict_taken    = ctr[CTR_W-1];
    result.predicted_target = (tag_hit && result.predict_taken) ? shadow_target[tidx]
                                                                : lhbp_pkg::NO_TARGET;
    result.mispredicted     = 1'b0;
    if (item.mode == lhbp_pkg::MODE_UPDATE) begin
      // Correct only when buffer presence and direction both agree with
      // the outcome.
      result.mispredicted = !((tag_hit && result.predict_taken && item.taken) ||
                              (!tag_hit && !result.predict_taken && !item.taken));
      if (!result.predict_taken && item.taken) begin
        ctr = ctr + 1'b1;
      end else if (result.predict_taken && !item.taken) begin
        ctr = ctr - 1'b1;
      end
      shadow_counter[hist] = ctr;
      shadow_history[hidx] = {hist[HIST_W-2:0], item.taken};
      if (result.mispredicted && item.taken) begin
        shadow_tag[tidx]    = item.pc;
        shadow_target[tidx] = item.actual_target;
      end
    end
    return result;
  endfunction

  // Presents one request and waits for its transfer. Payload changes only
  // on the falling edge; valid is held until the transfer.
  task automatic send_request(input logic mode, input logic [PCW-1:0] pc,
                              input logic taken, input logic [PCW-1:0] target);
    lhbp_pkg::req_t item;
    item.mode          = mode;
    item.pc            = pc;
    item.taken         = taken;
    item.actual_target = target;
    @(negedge clk);
    if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req       = item;
    req_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (req_ready) break;
    end
    owed_predictions.push_back(predict_and_train(item));
    if (mode == lhbp_pkg::MODE_UPDATE) updates_sent++;
    else lookups_sent++;
  endtask

  // Outcome of the next resolution of a recurring branch.
  task automatic resolve_outcome(input int k, output logic taken);
    case (pool_habit[k])
      ALWAYS_TAKEN: taken = 1'b1;
      NEVER_TAKEN:  taken = 1'b0;
      LOOP_EXIT:    taken = (pool_visits[k] % pool_period[k]) != 0;
      default:      taken = 1'($urandom_range(0, 1));
    endcase
    pool_visits[k]++;
  endtask

  // Right after reset every tag is zero and every counter predicts not
  // taken; the extremes of the address are looked up and resolved.
  task automatic test_cold_tables();
    send_request(lhbp_pkg::MODE_PREDICT, 32'h0000_0000, 1'b0, 32'h0000_0000);
    send_request(lhbp_pkg::MODE_PREDICT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // Tag miss, predicted not taken and not taken: a correct prediction.
    send_request(lhbp_pkg::MODE_UPDATE,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
    // Tag hit on the zero address but predicted not taken: mispredicted.
    send_request(lhbp_pkg::MODE_UPDATE,  32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
  endtask

  // Two taken updates on other branches push the shared counter into the
  // upper half, after which address zero hits its reset tag with target zero.
  task automatic test_zero_address_hit();
    send_request(lhbp_pkg::MODE_UPDATE,  32'h0000_0001, 1'b1, 32'hFFFF_FFFF);
    send_request(lhbp_pkg::MODE_UPDATE,  32'h0000_0002, 1'b1, 32'h0000_1234);
    send_request(lhbp_pkg::MODE_PREDICT, 32'h0000_0000, 1'b0, 32'h0000_0000);
  endtask

  // A hit that is predicted and actually taken trains without a buffer
  // write; the next lookup then uses the shifted history.
  task automatic test_correct_taken();
    send_request(lhbp_pkg::MODE_UPDATE,  32'h0000_0000, 1'b1, 32'hDEAD_BEEF);
    send_request(lhbp_pkg::MODE_PREDICT, 32'h0000_0000, 1'b0, 32'h0000_0000);
  endtask

  // Aliasing addresses that share indexes but not tags, a counter stepping
  // down, and a buffer entry written then read back.
  task automatic test_alias_and_step_down();
    send_request(lhbp_pkg::MODE_UPDATE,  32'h8000_0001, 1'b1, 32'hA5A5_A5A5);
    send_request(lhbp_pkg::MODE_PREDICT, 32'h0000_0001, 1'b0, 32'h0000_0000);
    send_request(lhbp_pkg::MODE_PREDICT, 32'h8000_0001, 1'b0, 32'h0000_0000);
    send_request(lhbp_pkg::MODE_UPDATE,  32'h0000_0003, 1'b0, 32'h5A5A_5A5A);
    send_request(lhbp_pkg::MODE_PREDICT, 32'h0000_0003, 1'b0, 32'h0000_0000);
    repeat (3) send_request(lhbp_pkg::MODE_UPDATE, 32'h0000_0055, 1'b1, 32'h0000_0F00);
    send_request(lhbp_pkg::MODE_PREDICT, 32'h0000_0055, 1'b1, 32'hFFFF_FFFF);
    send_request(lhbp_pkg::MODE_UPDATE,  32'h0000_0055, 1'b0, 32'h0000_0000);
  endtask

  task automatic build_branch_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        // Same table indexes as an earlier branch, different full address.
        pool_pc[i] = pool_pc[$urandom_range(0, i - 1)] ^ ({$urandom} << HIST_IDX_W);
      end else if (i > 0 && $urandom_range(0, 4) == 0) begin
        // Same buffer entry, different history register.
        pool_pc[i] = pool_pc[$urandom_range(0, i - 1)] ^ (32'h1 << TGT_IDX_W);
      end else begin
        pool_pc[i] = $urandom;
      end
      pool_target[i] = $urandom;
      pool_habit[i]  = branch_habit_t'($urandom_range(0, 3));
      pool_period[i] = $urandom_range(2, 5);
      pool_visits[i] = 0;
    end
  endtask

  // Mostly lookup-then-resolve pairs on recurring branches, as a pipeline
  // would issue them, with lone updates and fully random requests mixed in.
  task automatic test_random_traffic(input int count, input int gap_pct,
                                     input int stall_pct);
    int   issued;
    int   pick;
    int   k;
    logic outcome;
    logic [PCW-1:0] target;
    req_gap_pct   = gap_pct;
    rsp_stall_pct = stall_pct;
    issued        = 0;
    while (issued < count) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 85) begin
        if (pick < 70) begin
          send_request(lhbp_pkg::MODE_PREDICT, pool_pc[k], 1'($urandom_range(0, 1)),
                       $urandom);
          issued++;
        end
        resolve_outcome(k, outcome);
        // Occasionally the branch resolves to a new target.
        target = ($urandom_range(0, 9) == 0) ? $urandom : pool_target[k];
        send_request(lhbp_pkg::MODE_UPDATE, pool_pc[k], outcome, target);
        issued++;
      end else begin
        send_request(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                     $urandom);
        issued++;
      end
    end
  endtask

  // Response side idling: random bursts of back-pressure.
  always begin
    @(negedge clk);
    if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
      rsp_ready = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      rsp_ready = 1'b1;
    end
  end

  // Each result transfer is checked against the oldest owed prediction.
  always @(posedge clk) begin
    lhbp_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (owed_predictions.size() == 0) begin
        $error("rsp: result transfer with no request outstanding");
        mismatches++;
      end else begin
        want = owed_predictions.pop_front();
        if (want.mispredicted) mispredicts++;
        if (want.predicted_target != lhbp_pkg::NO_TARGET) target_hits++;
        if (rsp.predict_taken !== want.predict_taken) begin
          $error("predict_taken: expected %0d, actual %0d",
                 want.predict_taken, rsp.predict_taken);
          mismatches++;
        end
        if (rsp.predicted_target !== want.predicted_target) begin
          $error("predicted_target: expected %h, actual %h",
                 want.predicted_target, rsp.predicted_target);
          mismatches++;
        end
        if (rsp.mispredicted !== want.mispredicted) begin
          $error("mispredicted: expected %0d, actual %0d",
                 want.mispredicted, rsp.mispredicted);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if neither channel has seen a transfer for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    foreach (shadow_history[i]) shadow_history[i] = '0;
    foreach (shadow_counter[i]) shadow_counter[i] = '0;
    foreach (shadow_tag[i])     shadow_tag[i]     = '0;
    foreach (shadow_target[i])  shadow_target[i]  = '0;
    build_branch_pool();

    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_cold_tables();
    test_zero_address_hit();
    test_correct_taken();
    test_alias_and_step_down();
    // The directed part runs with no idling; the random part first with
    // moderate then heavy idling, and the last stretch with none at all.
    test_random_traffic(300, 20, 20);
    test_random_traffic(250, 50, 50);
    test_random_traffic(250, 0, 0);

    @(negedge clk);
    req_valid = 1'b0;
    while (owed_predictions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d lookups and %0d updates with %0d results checked,",
             lookups_sent, updates_sent, results_seen);
    $display("including %0d mispredictions and %0d buffer target hits.",
             mispredicts, target_hits);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
